// File: hdl/utf8_validating_byte_decoder_defines.svh
// assertion macros used by the decoder rtl
`ifndef UTF8_VALIDATING_BYTE_DECODER_DEFINES_SVH
`define UTF8_VALIDATING_BYTE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define UTF8VD_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("utf8 decoder check failed");
`define UTF8VD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("utf8 decoder sequencing check failed");
`else
`define UTF8VD_ASSERT(lbl, clk, rstn, prop)
`define UTF8VD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: hdl/utf8vd_pkg.sv
`timescale 1ns / 1ps

package utf8vd_pkg;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_DONE    = 2'd1,
        ST_ERROR   = 2'd2
    } utf8vd_status_t;

    localparam logic [20:0] CP_MAX      = 21'h10FFFF;
    localparam logic [20:0] SURR_LO     = 21'h00D800;
    localparam logic [20:0] SURR_HI     = 21'h00DFFF;
    localparam logic [20:0] MIN_CP2     = 21'h000080;
    localparam logic [20:0] MIN_CP3     = 21'h000800;
    localparam logic [20:0] MIN_CP4     = 21'h010000;
    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_BITS   = 8'h80;

    localparam logic [2:0]  LEN_NONE = 3'd0;
    localparam logic [2:0]  LEN_TWO  = 3'd2;
    localparam logic [2:0]  LEN_THREE = 3'd3;
    localparam logic [2:0]  LEN_FOUR = 3'd4;

    // bytes gathered so far (0 = idle) and total length of the sequence
    typedef struct packed {
        logic [1:0] held;
        logic [2:0] needed;
    } utf8vd_state_t;

    typedef struct packed {
        utf8vd_status_t status;
        logic [2:0]     seq_length;
        logic [20:0]    code_point;
    } utf8vd_result_t;

    // which byte slot to capture this cycle
    typedef struct packed {
        logic lead;
        logic mid1;
        logic mid2;
    } utf8vd_wr_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] n;
        case (b) inside
            [8'hC2:8'hDF]: n = LEN_TWO;
            [8'hE0:8'hEF]: n = LEN_THREE;
            [8'hF0:8'hF4]: n = LEN_FOUR;
            default:       n = LEN_NONE;
        endcase
        return n;
    endfunction

endpackage

// File: hdl/utf8_validating_byte_decoder.sv
`timescale 1ns / 1ps
// channel  | ports                                         | direction
// ---------+-----------------------------------------------+----------
// input    | s_valid, s_ready, s_data_byte                 | in
// result   | m_valid, m_ready, m_status, m_seq_length,     | out
//          | m_code_point                                  |
//
// one byte per cycle sustained while m_ready does not stall; a result shows on m_* once its byte
// has passed the input register and been decoded into the result register
// every accepted byte gives exactly one result request
// aresetn (synchronous, active low) returns the decoder to idle with both stages empty
// a stalled m_ready holds the result; the input register still takes one more byte if it is empty

module utf8_validating_byte_decoder
    import utf8vd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_seq_length,
    output logic [20:0] m_code_point
);

`include "utf8_validating_byte_decoder_defines.svh"

    logic           in_valid_reg;
    logic [7:0]     in_byte_reg;
    logic           out_valid_reg;
    utf8vd_result_t out_reg;
    utf8vd_state_t  state_reg;
    utf8vd_state_t  state_next;
    logic [7:0]     lead_reg;
    logic [7:0]     mid1_reg;
    logic [7:0]     mid2_reg;
    utf8vd_wr_t     wr;
    utf8vd_result_t result;
    logic           adv;
    logic           fire;
    logic           out_done;
    logic           out_quiet;
    logic           out_len_ok;
    logic           held_ok;
    logic           seq_end;

    // result slot free or being drained this cycle
    assign adv     = !out_valid_reg || m_ready;
    assign fire    = in_valid_reg && adv;
    assign s_ready = !in_valid_reg || adv;

    utf8vd_step u_step (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .lead_byte  (lead_reg),
        .mid1_byte  (mid1_reg),
        .mid2_byte  (mid2_reg),
        .state_next (state_next),
        .wr         (wr),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
        end
        if (fire) begin
            out_reg <= result;
            if (wr.lead) begin
                lead_reg <= in_byte_reg;
            end
            if (wr.mid1) begin
                mid1_reg <= in_byte_reg;
            end
            if (wr.mid2) begin
                mid2_reg <= in_byte_reg;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_reg.status;
    assign m_seq_length = out_reg.seq_length;
    assign m_code_point = out_reg.code_point;

    assign out_done   = m_valid && (m_status == ST_DONE);
    assign out_quiet  = (m_seq_length == LEN_NONE) && (m_code_point == 21'd0);
    assign out_len_ok = (m_seq_length == LEN_TWO) || (m_seq_length == LEN_THREE)
                        || (m_seq_length == LEN_FOUR);
    assign held_ok    = (state_reg.held == 2'd0) || ({1'b0, state_reg.held} < state_reg.needed);
    assign seq_end    = fire && (result.status != ST_PENDING);

    `UTF8VD_ASSERT(a_quiet_fields, aclk, aresetn, !m_valid || out_done || out_quiet)
    `UTF8VD_ASSERT(a_done_legal, aclk, aresetn, !out_done || (out_len_ok && m_code_point <= CP_MAX))
    `UTF8VD_ASSERT(a_held_below_needed, aclk, aresetn, held_ok)
    `UTF8VD_ASSERT_NEXT(a_idle_after_end, aclk, aresetn, seq_end, state_reg.held == 2'd0)

endmodule

// File: hdl/utf8vd_step.sv
`timescale 1ns / 1ps

module utf8vd_step
    import utf8vd_pkg::*;
(
    input  utf8vd_state_t  state,
    input  logic [7:0]     data_byte,
    input  logic [7:0]     lead_byte,
    input  logic [7:0]     mid1_byte,
    input  logic [7:0]     mid2_byte,
    output utf8vd_state_t  state_next,
    output utf8vd_wr_t     wr,
    output utf8vd_result_t result
);

    logic [2:0]  held_inc;
    logic [2:0]  lead_n;
    logic [20:0] cp;
    logic [20:0] cp_min;
    logic        bad;

    assign held_inc = {1'b0, state.held} + 3'd1;
    assign lead_n   = lead_length(data_byte);

    always_comb begin
        case (held_inc)
            LEN_TWO: begin
                cp     = {10'd0, lead_byte[4:0], data_byte[5:0]};
                cp_min = MIN_CP2;
            end
            LEN_THREE: begin
                cp     = {5'd0, lead_byte[3:0], mid1_byte[5:0], data_byte[5:0]};
                cp_min = MIN_CP3;
            end
            default: begin
                cp     = {lead_byte[2:0], mid1_byte[5:0], mid2_byte[5:0], data_byte[5:0]};
                cp_min = MIN_CP4;
            end
        endcase
    end

    assign bad = (cp < cp_min) || (cp > CP_MAX) || ((cp >= SURR_LO) && (cp <= SURR_HI));

    always_comb begin
        state_next        = state;
        wr                = '0;
        result.status     = ST_PENDING;
        result.seq_length = 3'd0;
        result.code_point = 21'd0;
        if (state.held == 2'd0) begin
            if (lead_n == LEN_NONE) begin
                result.status = ST_ERROR;
                state_next    = '0;
            end else begin
                wr.lead           = 1'b1;
                state_next.held   = 2'd1;
                state_next.needed = lead_n;
            end
        end else if ((data_byte & CONT_MASK) != CONT_BITS) begin
            // dropped, not taken as a new lead
            result.status = ST_ERROR;
            state_next    = '0;
        end else if (held_inc >= state.needed) begin
            state_next = '0;
            if (bad) begin
                result.status = ST_ERROR;
            end else begin
                result.status     = ST_DONE;
                result.seq_length = held_inc;
                result.code_point = cp;
            end
        end else begin
            wr.mid1         = (state.held == 2'd1);
            wr.mid2         = (state.held == 2'd2);
            state_next.held = held_inc[1:0];
        end
    end

endmodule
